@@ sv/mmm_pkg.sv @@
// Shared types and constants for the multichannel moving median unit.
package mmm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FIELD_W  = 8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK_IN,
        ST_CUR_UPD,
        ST_CAND_RD,
        ST_CAND_LD,
        ST_SWEEP,
        ST_TALLY,
        ST_PICK,
        ST_DONE
    } mmm_state_t;

    typedef struct packed {
        logic load;
        logic cmp_en;
    } mmm_rank_ctl_t;

endpackage

@@ sv/multichannel_moving_median_unit.sv @@
// Top level of the multichannel moving median unit: sequencer, cursors, output register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_channel               | in
//          | s_window_width s_sample                 |
//  result  | m_valid m_ready m_median m_invalid      | out
//
// For a valid item of width w, each of up to w candidates is read,
// then compared against all w ring entries through the single compare of the rank unit.
// An invalid item skips straight to the result. One item is worked on at a time.
// After reset a clearing pass over all ring addresses zeroes the ring and the cursors;
// s_ready stays low until it ends. A stalled result holds in the output register.
module multichannel_moving_median_unit #(
    parameter int CHANNELS   = 32,
    parameter int WINDOW_MAX = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mmm_pkg::FIELD_W-1:0]            s_channel,
    input  logic [mmm_pkg::FIELD_W-1:0]            s_window_width,
    input  logic signed [mmm_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mmm_pkg::SAMPLE_W-1:0]    m_median,
    output logic                                   m_invalid
);

    localparam int DEPTH  = CHANNELS * WINDOW_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW     = mmm_pkg::FIELD_W;
    localparam int SW     = mmm_pkg::SAMPLE_W;

    mmm_pkg::mmm_state_t state_reg, state_next;

    logic [ADDR_W-1:0]     clear_cnt_reg, clear_cnt_next;
    logic [FW-1:0]         ch_reg, ch_next;
    logic [FW-1:0]         w_reg, w_next;
    logic signed [SW-1:0]  smp_reg, smp_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      jd_reg, jd_next;
    logic                  pend_reg, pend_next;
    logic signed [SW-1:0]  res_med_reg, res_med_next;
    logic                  res_inv_reg, res_inv_next;
    logic                  m_valid_reg;
    logic signed [SW-1:0]  m_median_reg;
    logic                  m_invalid_reg;

    // per-channel cursor store
    logic [IDX_W-1:0]      cursor_mem [CHANNELS];
    logic [IDX_W-1:0]      cur_rd_reg;
    logic                  cur_we;
    logic [CH_W-1:0]       cur_waddr;
    logic [IDX_W-1:0]      cur_wdata;
    logic [IDX_W-1:0]      cur_new;
    logic [FW:0]           cur_inc;

    logic                  ring_we;
    logic [ADDR_W-1:0]     ring_waddr;
    logic signed [SW-1:0]  ring_wdata;
    logic [ADDR_W-1:0]     ring_raddr;
    logic signed [SW-1:0]  ring_rdata;

    mmm_pkg::mmm_rank_ctl_t rank_ctl;
    logic signed [SW-1:0]  rank_cand;
    logic [IDX_W-1:0]      rank_count;

    logic                  in_ok;
    logic                  out_free;
    logic                  sweep_last;
    logic                  pick_hit;

    assign in_ok = ({1'b0, ch_reg} < (FW + 1)'(CHANNELS)) && (w_reg != '0) &&
                   ({1'b0, w_reg} < (FW + 1)'(WINDOW_MAX));
    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_last = (FW'(j_reg) == (w_reg - FW'(1)));
    assign pick_hit   = (FW'(rank_count) == (w_reg >> 1));

    assign cur_inc = (FW + 1)'(cur_rd_reg) + (FW + 1)'(1);
    assign cur_new = (cur_inc >= {1'b0, w_reg}) ? '0 : IDX_W'(cur_inc);

    mmm_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    mmm_rank #(
        .IDX_W (IDX_W)
    ) u_rank (
        .aclk     (aclk),
        .ctl      (rank_ctl),
        .data     (ring_rdata),
        .data_idx (jd_reg),
        .load_idx (i_reg),
        .cand     (rank_cand),
        .count    (rank_count)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmm_pkg::ST_CLEAR: begin
                if (clear_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = mmm_pkg::ST_IDLE;
                end
            end
            mmm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mmm_pkg::ST_CHECK_IN;
                end
            end
            mmm_pkg::ST_CHECK_IN: begin
                state_next = in_ok ? mmm_pkg::ST_CUR_UPD : mmm_pkg::ST_DONE;
            end
            mmm_pkg::ST_CUR_UPD:  state_next = mmm_pkg::ST_CAND_RD;
            mmm_pkg::ST_CAND_RD:  state_next = mmm_pkg::ST_CAND_LD;
            mmm_pkg::ST_CAND_LD:  state_next = mmm_pkg::ST_SWEEP;
            mmm_pkg::ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = mmm_pkg::ST_TALLY;
                end
            end
            mmm_pkg::ST_TALLY:    state_next = mmm_pkg::ST_PICK;
            mmm_pkg::ST_PICK: begin
                state_next = pick_hit ? mmm_pkg::ST_DONE : mmm_pkg::ST_CAND_RD;
            end
            mmm_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mmm_pkg::ST_IDLE;
                end
            end
            default:              state_next = mmm_pkg::ST_CLEAR;
        endcase
    end

    // datapath controls and register next values
    always_comb begin
        clear_cnt_next = clear_cnt_reg;
        ch_next        = ch_reg;
        w_next         = w_reg;
        smp_next       = smp_reg;
        base_next      = base_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pend_next      = 1'b0;
        res_med_next   = res_med_reg;
        res_inv_next   = res_inv_reg;
        cur_we         = 1'b0;
        cur_waddr      = ch_reg[CH_W-1:0];
        cur_wdata      = cur_new;
        ring_we        = 1'b0;
        ring_waddr     = base_reg + ADDR_W'(cur_new);
        ring_wdata     = smp_reg;
        ring_raddr     = base_reg + ADDR_W'(i_reg);
        rank_ctl       = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            mmm_pkg::ST_CLEAR: begin
                clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
                ring_we        = 1'b1;
                ring_waddr     = clear_cnt_reg;
                ring_wdata     = '0;
                cur_we         = ({1'b0, clear_cnt_reg} < (ADDR_W + 1)'(CHANNELS));
                cur_waddr      = clear_cnt_reg[CH_W-1:0];
                cur_wdata      = '0;
            end
            mmm_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                ch_next  = s_channel;
                w_next   = s_window_width;
                smp_next = s_sample;
            end
            mmm_pkg::ST_CHECK_IN: begin
                base_next    = ADDR_W'(ch_reg[CH_W-1:0] * WINDOW_MAX);
                res_med_next = '0;
                res_inv_next = 1'b1;
            end
            mmm_pkg::ST_CUR_UPD: begin
                cur_we  = 1'b1;
                ring_we = 1'b1;
                i_next  = '0;
            end
            mmm_pkg::ST_CAND_RD: begin
                ring_raddr = base_reg + ADDR_W'(i_reg);
            end
            mmm_pkg::ST_CAND_LD: begin
                rank_ctl.load = 1'b1;
                j_next        = '0;
            end
            mmm_pkg::ST_SWEEP: begin
                ring_raddr      = base_reg + ADDR_W'(j_reg);
                pend_next       = 1'b1;
                jd_next         = j_reg;
                j_next          = j_reg + IDX_W'(1);
                rank_ctl.cmp_en = pend_reg;
            end
            mmm_pkg::ST_TALLY: begin
                rank_ctl.cmp_en = pend_reg;
            end
            mmm_pkg::ST_PICK: begin
                i_next = i_reg + IDX_W'(1);
                if (pick_hit) begin
                    res_med_next = rank_cand;
                    res_inv_next = 1'b0;
                end
            end
            mmm_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mmm_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg      <= ch_next;
        w_reg       <= w_next;
        smp_reg     <= smp_next;
        base_reg    <= base_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        jd_reg      <= jd_next;
        res_med_reg <= res_med_next;
        res_inv_reg <= res_inv_next;
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cursor_mem[cur_waddr] <= cur_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        cur_rd_reg <= cursor_mem[ch_reg[CH_W-1:0]];
    end

    // hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == mmm_pkg::ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == mmm_pkg::ST_DONE) && out_free) begin
            m_median_reg  <= res_med_reg;
            m_invalid_reg <= res_inv_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_median  = m_median_reg;
    assign m_invalid = m_invalid_reg;

endmodule

@@ sv/mmm_ring.sv @@
// Sample ring store: one write port, one registered read port.
module mmm_ring #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [ADDR_W-1:0]                      waddr,
    input  logic signed [mmm_pkg::SAMPLE_W-1:0]    wdata,
    input  logic [ADDR_W-1:0]                      raddr,
    output logic signed [mmm_pkg::SAMPLE_W-1:0]    rdata
);

    logic signed [mmm_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic signed [mmm_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mmm_rank.sv @@
// Shared rank unit: one signed compare per cycle against the held candidate.
module mmm_rank #(
    parameter int IDX_W = 6
) (
    input  logic                                   aclk,
    input  mmm_pkg::mmm_rank_ctl_t                 ctl,
    input  logic signed [mmm_pkg::SAMPLE_W-1:0]    data,
    input  logic [IDX_W-1:0]                       data_idx,
    input  logic [IDX_W-1:0]                       load_idx,
    output logic signed [mmm_pkg::SAMPLE_W-1:0]    cand,
    output logic [IDX_W-1:0]                       count
);

    logic signed [mmm_pkg::SAMPLE_W-1:0] cand_reg, cand_next;
    logic [IDX_W-1:0]                    cand_idx_reg, cand_idx_next;
    logic [IDX_W-1:0]                    count_reg, count_next;
    logic                                ranks_below;

    // equal samples are ordered by ring position, so every rank is unique
    assign ranks_below = (data < cand_reg) ||
                         ((data == cand_reg) && (data_idx < cand_idx_reg));

    always_comb begin
        cand_next     = cand_reg;
        cand_idx_next = cand_idx_reg;
        count_next    = count_reg;
        if (ctl.load) begin
            cand_next     = data;
            cand_idx_next = load_idx;
            count_next    = '0;
        end else if (ctl.cmp_en && ranks_below) begin
            count_next = count_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg     <= cand_next;
        cand_idx_reg <= cand_idx_next;
        count_reg    <= count_next;
    end

    assign cand  = cand_reg;
    assign count = count_reg;

endmodule
